>>> hw/rtl/mieu_pkg.sv
package mieu_pkg;

  localparam int XLEN = 64;

  // Operation codes.
  localparam logic [5:0] OP_ADD = 6'd0, OP_ADDI = 6'd1, OP_ADDIU = 6'd2, OP_ADDU = 6'd3,
    OP_AND = 6'd4, OP_ANDI = 6'd5, OP_BREAK = 6'd6, OP_DADD = 6'd7, OP_DADDI = 6'd8,
    OP_DADDIU = 6'd9, OP_DADDU = 6'd10, OP_DDIV = 6'd11, OP_DDIVU = 6'd12, OP_DIV = 6'd13,
    OP_DIVU = 6'd14, OP_DMULT = 6'd15, OP_DMULTU = 6'd16, OP_DSLL = 6'd17, OP_DSLLV = 6'd18,
    OP_DSRA = 6'd19, OP_DSRAV = 6'd20, OP_DSRL = 6'd21, OP_DSRLV = 6'd22, OP_DSUB = 6'd23,
    OP_DSUBU = 6'd24, OP_LUI = 6'd25, OP_MFHI = 6'd26, OP_MFLO = 6'd27, OP_MTHI = 6'd28,
    OP_MTLO = 6'd29, OP_MULT = 6'd30, OP_MULTU = 6'd31, OP_NOR = 6'd32, OP_OR = 6'd33,
    OP_ORI = 6'd34, OP_SLL = 6'd35, OP_SLLV = 6'd36, OP_SLT = 6'd37, OP_SLTI = 6'd38,
    OP_SLTIU = 6'd39, OP_SLTU = 6'd40, OP_SRA = 6'd41, OP_SRAV = 6'd42, OP_SRL = 6'd43,
    OP_SRLV = 6'd44, OP_SUB = 6'd45, OP_SUBU = 6'd46, OP_SYNC = 6'd47, OP_SYSCALL = 6'd48,
    OP_TEQ = 6'd49, OP_TEQI = 6'd50, OP_TGE = 6'd51, OP_TGEI = 6'd52, OP_TGEIU = 6'd53,
    OP_TGEU = 6'd54, OP_TLT = 6'd55, OP_TLTI = 6'd56, OP_TLTIU = 6'd57, OP_TLTU = 6'd58,
    OP_TNE = 6'd59, OP_TNEI = 6'd60, OP_XOR = 6'd61, OP_XORI = 6'd62;

  // Exception codes.
  localparam logic [2:0] EXC_NONE = 3'd0, EXC_OVF = 3'd1, EXC_TRAP = 3'd2,
    EXC_BREAK = 3'd3, EXC_SYSCALL = 3'd4;

  // Multiply-divide unit commands.
  localparam logic [1:0] MD_MULU = 2'd0, MD_DIVU = 2'd1;

  typedef struct packed {
    logic [5:0]      mode;
    logic [XLEN-1:0] operand_s;
    logic [XLEN-1:0] operand_t;
    logic [15:0]     immediate;
    logic [5:0]      shift_amount;
  } in_item_t;

  typedef struct packed {
    logic [XLEN-1:0] result;
    logic            writes_result;
    logic [2:0]      exception_code;
  } out_item_t;

  // Request to the multiply-divide unit: unsigned magnitudes.
  typedef struct packed {
    logic       start;
    logic [1:0] cmd;
  } md_ctrl_t;

  function automatic logic [XLEN-1:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

>>> hw/rtl/mieu_muldiv.sv
// Radix-2 unsigned multiply / restoring divide on 64-bit magnitudes.
module mieu_muldiv (
  input  logic                       clk,
  input  logic                       rst,
  input  mieu_pkg::md_ctrl_t         ctrl,
  input  logic [mieu_pkg::XLEN-1:0]  a,
  input  logic [mieu_pkg::XLEN-1:0]  b,
  output logic                       done,
  output logic [mieu_pkg::XLEN-1:0]  hi,
  output logic [mieu_pkg::XLEN-1:0]  lo
);
  import mieu_pkg::*;

  logic            busy;
  logic [6:0]      count;
  logic [1:0]      cmd;
  logic [XLEN-1:0] acc;
  logic [XLEN-1:0] quo;
  logic [XLEN-1:0] dvs;
  logic [XLEN:0]   madd;
  logic [XLEN:0]   rem_sh;
  logic [XLEN:0]   rem_sub;

  // One step of add-shift or shift-subtract.
  assign madd    = {1'b0, acc} + (quo[0] ? {1'b0, dvs} : '0);
  assign rem_sh  = {acc, quo[XLEN-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      count <= 7'(XLEN);
      cmd <= ctrl.cmd;
      acc <= '0;
      quo <= a;
      dvs <= b;
    end else if (busy) begin
      if (cmd == MD_MULU) begin
        acc <= madd[XLEN:1];
        quo <= {madd[0], quo[XLEN-1:1]};
      end else if (!rem_sub[XLEN]) begin
        acc <= rem_sub[XLEN-1:0];
        quo <= {quo[XLEN-2:0], 1'b1};
      end else begin
        acc <= rem_sh[XLEN-1:0];
        quo <= {quo[XLEN-2:0], 1'b0};
      end
      count <= count - 7'd1;
      if (count == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign hi = acc;
  assign lo = quo;

endmodule

>>> hw/rtl/mips64_integer_execute_unit.sv
// Integer execute unit with a shared HI/LO multiply-divide engine.
// Single-cycle operations pass from the input register through the execute state to the output state.
// Multiply and divide add a wait in the multiply-divide state, set by the 64-step shift loop;
// division by zero skips the loop and goes straight to the output like a single-cycle operation.
// The input stalls while an item is in flight or its result is not yet taken.
// Synchronous reset clears control state and the HI and LO registers.
module mips64_integer_execute_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mieu_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mieu_pkg::out_item_t  out_data
);
  import mieu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0, ST_EXEC = 2'd1, ST_MD = 2'd2, ST_OUT = 2'd3;

  logic [1:0]      state;
  in_item_t        item;
  logic [XLEN-1:0] hi_reg, lo_reg;
  logic [XLEN-1:0] s, t, imms, immz, sum, dif, res;
  logic [31:0]     a32, b32, sum32, dif32;
  logic [5:0]      vsa;
  logic            wr;
  logic [2:0]      exc;
  logic            is_md, is_div, is_signed, is_32;
  logic            neg_a, neg_b;
  logic [XLEN-1:0] opa, opb, ma, mb;
  md_ctrl_t        md_ctrl;
  logic            md_done;
  logic [XLEN-1:0] md_hi, md_lo, fhi, flo, nhi, nlo;
  logic            lt_s, lt_u, lt_si, lt_ui;

  assign s    = item.operand_s;
  assign t    = item.operand_t;
  assign a32  = s[31:0];
  assign b32  = t[31:0];
  assign imms = {{48{item.immediate[15]}}, item.immediate};
  assign immz = {48'd0, item.immediate};
  assign vsa  = s[5:0];

  // Shared adder: immediate forms select the immediate as second operand.
  always_comb begin
    unique case (item.mode)
      OP_ADDI, OP_ADDIU, OP_DADDI, OP_DADDIU: sum = s + imms;
      default: sum = s + t;
    endcase
  end
  assign dif   = s - t;
  assign sum32 = sum[31:0];
  assign dif32 = dif[31:0];
  assign lt_s  = $signed(s) < $signed(t);
  assign lt_u  = s < t;
  assign lt_si = $signed(s) < $signed(imms);
  assign lt_ui = s < imms;

  // Single-cycle result decode.
  always_comb begin
    res = '0;
    wr  = 1'b1;
    exc = EXC_NONE;
    unique case (item.mode)
      OP_ADD, OP_ADDI: begin
        if (~(a32[31] ^ (item.mode == OP_ADDI ? item.immediate[15] : b32[31]))
            & (a32[31] ^ sum32[31])) begin
          wr = 1'b0; exc = EXC_OVF;
        end else res = sx32(sum32);
      end
      OP_ADDIU, OP_ADDU: res = sx32(sum32);
      OP_AND:    res = s & t;
      OP_ANDI:   res = s & immz;
      OP_DADD, OP_DADDI: begin
        if (~(s[63] ^ (item.mode == OP_DADDI ? imms[63] : t[63])) & (s[63] ^ sum[63])) begin
          wr = 1'b0; exc = EXC_OVF;
        end else res = sum;
      end
      OP_DADDIU, OP_DADDU: res = sum;
      OP_DSLL:   res = t << item.shift_amount;
      OP_DSLLV:  res = t << vsa;
      OP_DSRA:   res = $signed(t) >>> item.shift_amount;
      OP_DSRAV:  res = $signed(t) >>> vsa;
      OP_DSRL:   res = t >> item.shift_amount;
      OP_DSRLV:  res = t >> vsa;
      OP_DSUB: begin
        if ((s[63] ^ t[63]) & (s[63] ^ dif[63])) begin
          wr = 1'b0; exc = EXC_OVF;
        end else res = dif;
      end
      OP_DSUBU:  res = dif;
      OP_LUI:    res = sx32({item.immediate, 16'd0});
      OP_MFHI:   res = hi_reg;
      OP_MFLO:   res = lo_reg;
      OP_NOR:    res = ~(s | t);
      OP_OR:     res = s | t;
      OP_ORI:    res = s | immz;
      OP_SLL:    res = sx32(b32 << item.shift_amount[4:0]);
      OP_SLLV:   res = sx32(b32 << vsa[4:0]);
      OP_SLT:    res = {63'd0, lt_s};
      OP_SLTI:   res = {63'd0, lt_si};
      OP_SLTIU:  res = {63'd0, lt_ui};
      OP_SLTU:   res = {63'd0, lt_u};
      OP_SRA:    res = sx32(32'($signed(b32) >>> item.shift_amount[4:0]));
      OP_SRAV:   res = sx32(32'($signed(b32) >>> vsa[4:0]));
      OP_SRL:    res = sx32(b32 >> item.shift_amount[4:0]);
      OP_SRLV:   res = sx32(b32 >> vsa[4:0]);
      OP_SUB: begin
        if ((a32[31] ^ b32[31]) & (a32[31] ^ dif32[31])) begin
          wr = 1'b0; exc = EXC_OVF;
        end else res = sx32(dif32);
      end
      OP_SUBU:   res = sx32(dif32);
      OP_XOR:    res = s ^ t;
      OP_XORI:   res = s ^ immz;
      default: begin
        wr = 1'b0;
        unique case (item.mode)
          OP_BREAK:   exc = EXC_BREAK;
          OP_SYSCALL: exc = EXC_SYSCALL;
          OP_TEQ:     exc = (s == t) ? EXC_TRAP : EXC_NONE;
          OP_TEQI:    exc = (s == imms) ? EXC_TRAP : EXC_NONE;
          OP_TGE:     exc = !lt_s ? EXC_TRAP : EXC_NONE;
          OP_TGEI:    exc = !lt_si ? EXC_TRAP : EXC_NONE;
          OP_TGEIU:   exc = !lt_ui ? EXC_TRAP : EXC_NONE;
          OP_TGEU:    exc = !lt_u ? EXC_TRAP : EXC_NONE;
          OP_TLT:     exc = lt_s ? EXC_TRAP : EXC_NONE;
          OP_TLTI:    exc = lt_si ? EXC_TRAP : EXC_NONE;
          OP_TLTIU:   exc = lt_ui ? EXC_TRAP : EXC_NONE;
          OP_TLTU:    exc = lt_u ? EXC_TRAP : EXC_NONE;
          OP_TNE:     exc = (s != t) ? EXC_TRAP : EXC_NONE;
          OP_TNEI:    exc = (s != imms) ? EXC_TRAP : EXC_NONE;
          default:    exc = EXC_NONE;
        endcase
      end
    endcase
  end

  // Multiply-divide operand preparation: magnitudes into the shared unit.
  always_comb begin
    is_md = 1'b1; is_div = 1'b0; is_signed = 1'b0; is_32 = 1'b0;
    unique case (item.mode)
      OP_DDIV:   begin is_div = 1'b1; is_signed = 1'b1; end
      OP_DDIVU:  is_div = 1'b1;
      OP_DIV:    begin is_div = 1'b1; is_signed = 1'b1; is_32 = 1'b1; end
      OP_DIVU:   begin is_div = 1'b1; is_32 = 1'b1; end
      OP_DMULT:  is_signed = 1'b1;
      OP_DMULTU: ;
      OP_MULT:   begin is_signed = 1'b1; is_32 = 1'b1; end
      OP_MULTU:  is_32 = 1'b1;
      default:   is_md = 1'b0;
    endcase
  end
  assign opa   = is_32 ? (is_signed ? sx32(a32) : {32'd0, a32}) : s;
  assign opb   = is_32 ? (is_signed ? sx32(b32) : {32'd0, b32}) : t;
  assign neg_a = is_signed & opa[63];
  assign neg_b = is_signed & opb[63];
  assign ma    = neg_a ? -opa : opa;
  assign mb    = neg_b ? -opb : opb;

  assign md_ctrl.start = (state == ST_EXEC) && is_md && !(is_div && opb == '0);
  assign md_ctrl.cmd   = is_div ? MD_DIVU : MD_MULU;

  mieu_muldiv u_md (
    .clk  (clk),
    .rst  (rst),
    .ctrl (md_ctrl),
    .a    (ma),
    .b    (mb),
    .done (md_done),
    .hi   (md_hi),
    .lo   (md_lo)
  );

  // Sign fixup of the unit's magnitudes into HI/LO.
  always_comb begin
    if (is_div) begin
      flo = (neg_a ^ neg_b) ? -md_lo : md_lo;
      fhi = neg_a ? -md_hi : md_hi;
    end else begin
      {fhi, flo} = (neg_a ^ neg_b) ? -{md_hi, md_lo} : {md_hi, md_lo};
    end
    if (is_32) begin
      if (is_div) begin
        nlo = sx32(flo[31:0]);
        nhi = sx32(fhi[31:0]);
      end else begin
        nlo = sx32(flo[31:0]);
        nhi = sx32(flo[63:32]);
      end
    end else begin
      nlo = flo;
      nhi = fhi;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hi_reg <= '0;
      lo_reg <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) begin
          item <= in_data;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          out_data.result <= wr ? res : '0;
          out_data.writes_result <= wr;
          out_data.exception_code <= exc;
          if (item.mode == OP_MTHI) hi_reg <= s;
          if (item.mode == OP_MTLO) lo_reg <= s;
          if (is_md && is_div && opb == '0) begin
            // Division by zero: HI takes the dividend, sign-extended for 32-bit forms.
            lo_reg <= (!is_signed || !opa[63]) ? '1 : 64'd1;
            hi_reg <= is_32 ? sx32(a32) : opa;
            state <= ST_OUT;
          end else if (is_md) begin
            state <= ST_MD;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_MD: if (md_done) begin
          hi_reg <= nhi;
          lo_reg <= nlo;
          state <= ST_OUT;
        end
        ST_OUT: if (!out_stall) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sim/tb_top.sv
module tb_top;
  import mieu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_ITEMS = 530;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  mips64_integer_execute_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Architectural HI/LO copy kept by the predictor.
  logic [63:0] hi_copy, lo_copy;
  out_item_t pending_results[$];
  int errors = 0;
  bit quiet_tail = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] sext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] sext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Computes the result of one instruction and updates the HI/LO copy.
  function automatic out_item_t execute_instruction(in_item_t it);
    out_item_t o;
    logic [63:0] s, t, imms, immz, res;
    logic [31:0] a32, b32, sum32;
    logic [63:0] sum;
    logic [127:0] prod;
    logic signed [63:0] ss, ts;
    logic signed [31:0] s32, t32;
    logic wr;
    logic [2:0] exc;
    s = it.operand_s;
    t = it.operand_t;
    imms = sext16(it.immediate);
    immz = {48'd0, it.immediate};
    a32 = s[31:0];
    b32 = t[31:0];
    ss = s;
    ts = t;
    s32 = a32;
    t32 = b32;
    res = '0;
    wr = 1'b1;
    exc = EXC_NONE;
    case (it.mode)
      OP_ADD, OP_ADDI: begin
        if (it.mode == OP_ADDI) b32 = imms[31:0];
        sum32 = a32 + b32;
        if (~(a32[31] ^ b32[31]) & (a32[31] ^ sum32[31])) begin
          exc = EXC_OVF;
          wr = 0;
        end else res = sext32(sum32);
      end
      OP_ADDIU: res = sext32(a32 + imms[31:0]);
      OP_ADDU: res = sext32(a32 + b32);
      OP_AND: res = s & t;
      OP_ANDI: res = s & immz;
      OP_BREAK: begin exc = EXC_BREAK; wr = 0; end
      OP_DADD, OP_DADDI: begin
        if (it.mode == OP_DADDI) t = imms;
        sum = s + t;
        if (~(s[63] ^ t[63]) & (s[63] ^ sum[63])) begin
          exc = EXC_OVF;
          wr = 0;
        end else res = sum;
      end
      OP_DADDIU: res = s + imms;
      OP_DADDU: res = s + t;
      OP_DDIV: begin
        wr = 0;
        if (t == 0) begin
          lo_copy = s[63] ? 64'd1 : ONES;
          hi_copy = s;
        end else if (s == MIN64 && t == ONES) begin
          lo_copy = MIN64;
          hi_copy = 0;
        end else begin
          lo_copy = ss / ts;
          hi_copy = ss % ts;
        end
      end
      OP_DDIVU: begin
        wr = 0;
        if (t == 0) begin lo_copy = ONES; hi_copy = s; end
        else begin lo_copy = s / t; hi_copy = s % t; end
      end
      OP_DIV: begin
        wr = 0;
        if (b32 == 0) begin
          lo_copy = a32[31] ? 64'd1 : ONES;
          hi_copy = sext32(a32);
        end else if (a32 == 32'h8000_0000 && b32 == 32'hFFFF_FFFF) begin
          lo_copy = sext32(32'h8000_0000);
          hi_copy = 0;
        end else begin
          lo_copy = sext32(s32 / t32);
          hi_copy = sext32(s32 % t32);
        end
      end
      OP_DIVU: begin
        wr = 0;
        if (b32 == 0) begin lo_copy = ONES; hi_copy = sext32(a32); end
        else begin lo_copy = sext32(a32 / b32); hi_copy = sext32(a32 % b32); end
      end
      OP_DMULT: begin
        wr = 0;
        prod = $signed({{64{s[63]}}, s}) * $signed({{64{t[63]}}, t});
        lo_copy = prod[63:0];
        hi_copy = prod[127:64];
      end
      OP_DMULTU: begin
        wr = 0;
        prod = {64'd0, s} * {64'd0, t};
        lo_copy = prod[63:0];
        hi_copy = prod[127:64];
      end
      OP_DSLL: res = t << it.shift_amount;
      OP_DSLLV: res = t << s[5:0];
      OP_DSRA: res = ts >>> it.shift_amount;
      OP_DSRAV: res = ts >>> s[5:0];
      OP_DSRL: res = t >> it.shift_amount;
      OP_DSRLV: res = t >> s[5:0];
      OP_DSUB: begin
        sum = s - t;
        if ((s[63] ^ t[63]) & (s[63] ^ sum[63])) begin
          exc = EXC_OVF;
          wr = 0;
        end else res = sum;
      end
      OP_DSUBU: res = s - t;
      OP_LUI: res = sext32({it.immediate, 16'd0});
      OP_MFHI: res = hi_copy;
      OP_MFLO: res = lo_copy;
      OP_MTHI: begin hi_copy = s; wr = 0; end
      OP_MTLO: begin lo_copy = s; wr = 0; end
      OP_MULT, OP_MULTU: begin
        wr = 0;
        if (it.mode == OP_MULT) prod = $signed({{96{a32[31]}}, a32}) *
                                       $signed({{96{b32[31]}}, b32});
        else prod = {96'd0, a32} * {96'd0, b32};
        lo_copy = sext32(prod[31:0]);
        hi_copy = sext32(prod[63:32]);
      end
      OP_NOR: res = ~(s | t);
      OP_OR: res = s | t;
      OP_ORI: res = s | immz;
      OP_SLL: res = sext32(b32 << it.shift_amount[4:0]);
      OP_SLLV: res = sext32(b32 << s[4:0]);
      OP_SLT: res = {63'd0, ss < ts};
      OP_SLTI: res = {63'd0, ss < $signed(imms)};
      OP_SLTIU: res = {63'd0, s < imms};
      OP_SLTU: res = {63'd0, s < t};
      OP_SRA: res = sext32(t32 >>> it.shift_amount[4:0]);
      OP_SRAV: res = sext32(t32 >>> s[4:0]);
      OP_SRL: res = sext32(b32 >> it.shift_amount[4:0]);
      OP_SRLV: res = sext32(b32 >> s[4:0]);
      OP_SUB: begin
        sum32 = a32 - b32;
        if ((a32[31] ^ b32[31]) & (a32[31] ^ sum32[31])) begin
          exc = EXC_OVF;
          wr = 0;
        end else res = sext32(sum32);
      end
      OP_SUBU: res = sext32(a32 - b32);
      OP_SYNC: wr = 0;
      OP_SYSCALL: begin exc = EXC_SYSCALL; wr = 0; end
      OP_TEQ: begin wr = 0; if (s == t) exc = EXC_TRAP; end
      OP_TEQI: begin wr = 0; if (s == imms) exc = EXC_TRAP; end
      OP_TGE: begin wr = 0; if (!(ss < ts)) exc = EXC_TRAP; end
      OP_TGEI: begin wr = 0; if (!(ss < $signed(imms))) exc = EXC_TRAP; end
      OP_TGEIU: begin wr = 0; if (s >= imms) exc = EXC_TRAP; end
      OP_TGEU: begin wr = 0; if (s >= t) exc = EXC_TRAP; end
      OP_TLT: begin wr = 0; if (ss < ts) exc = EXC_TRAP; end
      OP_TLTI: begin wr = 0; if (ss < $signed(imms)) exc = EXC_TRAP; end
      OP_TLTIU: begin wr = 0; if (s < imms) exc = EXC_TRAP; end
      OP_TLTU: begin wr = 0; if (s < t) exc = EXC_TRAP; end
      OP_TNE: begin wr = 0; if (s != t) exc = EXC_TRAP; end
      OP_TNEI: begin wr = 0; if (s != imms) exc = EXC_TRAP; end
      OP_XOR: res = s ^ t;
      OP_XORI: res = s ^ immz;
      default: wr = 0;
    endcase
    o.result = wr ? res : '0;
    o.writes_result = wr;
    o.exception_code = exc;
    return o;
  endfunction

  // Directed table; a row with a typed-in result is checked against it as well.
  typedef struct {
    in_item_t  instr;
    bit        has_known;
    out_item_t known;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic in_item_t make_instr(logic [5:0] m, logic [63:0] s, logic [63:0] t,
                                          logic [15:0] imm, logic [5:0] sa);
    in_item_t it;
    it.mode = m;
    it.operand_s = s;
    it.operand_t = t;
    it.immediate = imm;
    it.shift_amount = sa;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit known, logic [63:0] r, logic w,
                                  logic [2:0] e);
    directed_row_t row;
    row.instr = it;
    row.has_known = known;
    row.known.result = r;
    row.known.writes_result = w;
    row.known.exception_code = e;
    directed_rows.push_back(row);
  endfunction

  // Random operand biased toward corner values.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return ONES;
      2: return MIN64;
      3: return MIN64 - 64'd1;
      4: return sext32(32'h8000_0000);
      5: return {32'd0, $urandom()};
      6: return sext32($urandom());
      7: return 64'($urandom_range(0, 70));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic in_item_t random_instr();
    in_item_t it;
    it.mode = 6'($urandom_range(0, 63));
    it.operand_s = pick_operand();
    it.operand_t = pick_operand();
    it.immediate = 16'($urandom());
    it.shift_amount = 6'($urandom());
    // Give equality traps a fair chance to fire.
    if ($urandom_range(0, 7) == 0) it.operand_t = it.operand_s;
    return it;
  endfunction

  // Sends one instruction and records its expected result.
  task automatic send_instr(in_item_t it, bit known, out_item_t known_val);
    int gap;
    out_item_t expv;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expv = execute_instruction(it);
    if (known && expv !== known_val)
      $display("%0t directed row mismatch: expected %h actual %h", $time, known_val, expv);
    if (known && expv !== known_val) errors++;
    pending_results.push_back(expv);
    @(negedge clk);
  endtask

  // Receiver: random stall bursts, quiet at the end.
  initial begin
    int burst;
    @(negedge clk);
    while (1) begin
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_item_t expv;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        expv = pending_results.pop_front();
        if (out_data.result !== expv.result) begin
          $display("%0t result: expected %h actual %h", $time, expv.result, out_data.result);
          errors++;
        end
        if (out_data.writes_result !== expv.writes_result) begin
          $display("%0t writes_result: expected %b actual %b", $time,
                   expv.writes_result, out_data.writes_result);
          errors++;
        end
        if (out_data.exception_code !== expv.exception_code) begin
          $display("%0t exception_code: expected %0d actual %0d", $time,
                   expv.exception_code, out_data.exception_code);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    out_item_t none;
    int wait_cycles;
    none = '0;
    hi_copy = '0;
    lo_copy = '0;

    add_row(make_instr(OP_MFHI, 0, 0, 0, 0), 1, 0, 1, EXC_NONE);
    add_row(make_instr(OP_MFLO, ONES, 0, 0, 0), 1, 0, 1, EXC_NONE);
    add_row(make_instr(OP_ADD, 64'h7FFF_FFFF, 1, 0, 0), 1, 0, 0, EXC_OVF);
    add_row(make_instr(OP_ADDI, 64'h8000_0000, 0, 16'hFFFF, 0), 1, 0, 0, EXC_OVF);
    add_row(make_instr(OP_SUB, 64'h8000_0000, 1, 0, 0), 1, 0, 0, EXC_OVF);
    add_row(make_instr(OP_DADD, MIN64 - 1, 1, 0, 0), 1, 0, 0, EXC_OVF);
    add_row(make_instr(OP_DADDI, MIN64, 0, 16'hFFFF, 0), 1, 0, 0, EXC_OVF);
    add_row(make_instr(OP_DSUB, MIN64, 1, 0, 0), 1, 0, 0, EXC_OVF);
    add_row(make_instr(OP_BREAK, ONES, ONES, 16'hFFFF, 6'h3F), 1, 0, 0, EXC_BREAK);
    add_row(make_instr(OP_SYSCALL, 0, 0, 0, 0), 1, 0, 0, EXC_SYSCALL);
    add_row(make_instr(OP_TEQ, ONES, ONES, 0, 0), 1, 0, 0, EXC_TRAP);
    add_row(make_instr(6'd63, ONES, ONES, 16'hFFFF, 6'h3F), 1, 0, 0, EXC_NONE);
    add_row(make_instr(OP_DDIV, MIN64, ONES, 0, 0), 0, 0, 0, 0);
    add_row(make_instr(OP_MFLO, 0, 0, 0, 0), 1, MIN64, 1, EXC_NONE);
    add_row(make_instr(OP_DIV, 64'h8000_0000, ONES, 0, 0), 0, 0, 0, 0);
    add_row(make_instr(OP_MFLO, 0, 0, 0, 0), 1, sext32(32'h8000_0000), 1, EXC_NONE);
    add_row(make_instr(OP_DDIV, ONES, 0, 0, 0), 0, 0, 0, 0);
    add_row(make_instr(OP_MFLO, 0, 0, 0, 0), 1, 1, 1, EXC_NONE);
    add_row(make_instr(OP_DIVU, 5, 0, 0, 0), 0, 0, 0, 0);
    add_row(make_instr(OP_MFHI, 0, 0, 0, 0), 1, 5, 1, EXC_NONE);
    add_row(make_instr(OP_DMULT, MIN64, MIN64, 0, 0), 0, 0, 0, 0);
    add_row(make_instr(OP_MFHI, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(make_instr(OP_DSRA, MIN64, MIN64, 0, 6'h3F), 1, ONES, 1, EXC_NONE);
    add_row(make_instr(OP_SLL, 0, 1, 0, 6'h3F), 1, sext32(32'h8000_0000), 1, EXC_NONE);
    add_row(make_instr(OP_LUI, 0, 0, 16'hFFFF, 0), 1, 64'hFFFF_FFFF_FFFF_0000, 1,
            EXC_NONE);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_instr(directed_rows[i].instr, directed_rows[i].has_known, directed_rows[i].known);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - 60) quiet_tail = 1;
      send_instr(random_instr(), 0, none);
    end
    in_valid <= 1'b0;

    // Drain, then allow the multiply-divide latency to settle.
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (80) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
